FILE: rtl/core/hashed_timer_wheel_macros.svh
// Assertion macros used by the hashed timer wheel RTL.
`ifndef HASHED_TIMER_WHEEL_MACROS_SVH
`define HASHED_TIMER_WHEEL_MACROS_SVH
`ifndef ASSERT_OFF
// Checked at every clock edge outside reset.
`define HTW_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every clock edge, reset included.
`define HTW_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HTW_ASSERT(label, clk, rst_n, prop, msg)
`define HTW_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

FILE: rtl/core/htw_pkg.sv
// Shared constants and transaction types of the hashed timer wheel.
`timescale 1ns / 1ps
`default_nettype none
package htw_pkg;
	localparam int WHEEL_BITS = 5;
	localparam int NUM_TIMERS = 32;
	localparam int DELAY_BITS = 24;
	localparam int ROUND_BITS = DELAY_BITS - WHEEL_BITS;
	localparam int ID_BITS    = 5;
	localparam int IDX_BITS   = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam int CNT_BITS   = $clog2(NUM_TIMERS + 1);
	localparam int ENTRY_BITS = WHEEL_BITS + ROUND_BITS;

	localparam logic [1:0] MODE_TICK  = 2'd0;
	localparam logic [1:0] MODE_START = 2'd1;
	localparam logic [1:0] MODE_STOP  = 2'd2;

	localparam logic [1:0] KIND_EXPIRE = 2'd0;
	localparam logic [1:0] KIND_START  = 2'd1;
	localparam logic [1:0] KIND_STOP   = 2'd2;

	typedef struct packed {
		logic [1:0]            mode;
		logic [ID_BITS-1:0]    timer_id;
		logic [DELAY_BITS-1:0] delay_ticks;
	} cmd_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic [ID_BITS-1:0] timer_id_res;
		logic               was_pending;
		logic               last;
	} evt_t;
endpackage
`default_nettype wire

FILE: rtl/core/htw_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
`default_nettype none
module htw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

FILE: rtl/core/hashed_timer_wheel.sv
// Top level of the hashed timer wheel: command decode, slot scan and result output.
//
//   Channel  Dir  Handshake           Payload
//   cmd      in   cmd_valid/cmd_stall cmd   (mode, timer_id, delay_ticks)
//   evt      out  evt_valid/evt_stall evt   (kind, timer_id_res, was_pending, last)
//
// A start or stop is written to the output register from S_EXEC once the register is free, and
// no further command is accepted before that.
// During a tick the scan reads one timer entry per cycle from the entry RAM, unless frozen
// by a stall on evt, and writes back decremented round counts behind the read.
// One command is in flight at a time; the next is accepted once the scan or update is done,
// even while the last result still waits in the output register.
// A stall on evt freezes the scan when a further expiry must be pushed out.
// Reset clears the tick count, all armed flags and the output register; no RAM sweep is needed.
`timescale 1ns / 1ps
`default_nettype none
`include "hashed_timer_wheel_macros.svh"
module hashed_timer_wheel (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cmd_valid,
	output logic               cmd_stall,
	input  wire htw_pkg::cmd_t cmd,
	output logic               evt_valid,
	input  wire logic          evt_stall,
	output htw_pkg::evt_t      evt
);
	import htw_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_SCAN,
		S_FLUSH
	} state_t;

	state_t                state_q;
	cmd_t                  cmd_q;
	logic [WHEEL_BITS-1:0] tick_q;
	logic [NUM_TIMERS-1:0] pending_q;
	logic                  out_valid_q;
	evt_t                  out_q;
	logic                  held_v_q;
	logic [IDX_BITS-1:0]   held_id_q;
	logic [CNT_BITS-1:0]   rd_idx_q;
	logic                  v_s1;
	logic [IDX_BITS-1:0]   idx_s1;

	logic                  out_free;
	logic                  out_load;
	logic                  id_ok;
	logic [IDX_BITS-1:0]   cmd_idx;
	logic [DELAY_BITS-1:0] delay_m1;
	logic [WHEEL_BITS-1:0] start_slot;
	logic [ENTRY_BITS-1:0] rdata;
	logic [WHEEL_BITS-1:0] rd_slot;
	logic [ROUND_BITS-1:0] rd_rounds;
	logic                  hit;
	logic                  expire;
	logic                  freeze;
	logic                  rd_more;
	logic                  ram_we;
	logic [IDX_BITS-1:0]   ram_waddr;
	logic [ENTRY_BITS-1:0] ram_wdata;
	logic                  ram_re;

	assign out_free   = !out_valid_q || !evt_stall;
	assign id_ok      = {1'b0, cmd_q.timer_id} < (ID_BITS + 1)'(NUM_TIMERS);
	assign cmd_idx    = IDX_BITS'(cmd_q.timer_id);
	assign delay_m1   = (cmd_q.delay_ticks == '0) ? '0 : cmd_q.delay_ticks - 1'b1;
	assign start_slot = tick_q + delay_m1[WHEEL_BITS-1:0] + 1'b1;

	assign rd_slot   = rdata[ENTRY_BITS-1:ROUND_BITS];
	assign rd_rounds = rdata[ROUND_BITS-1:0];
	assign hit       = v_s1 && pending_q[idx_s1] && (rd_slot == tick_q);
	assign expire    = hit && (rd_rounds == '0);
	// A second expiry must push the held one out; wait for room in the output register.
	assign freeze    = expire && held_v_q && !out_free;
	assign rd_more   = rd_idx_q < CNT_BITS'(NUM_TIMERS);
	assign ram_re    = (state_q == S_SCAN) && !freeze && rd_more;

	// The output register takes a new transaction in exactly these cases.
	assign out_load = ((state_q == S_EXEC) && out_free &&
			((cmd_q.mode == MODE_START) || (cmd_q.mode == MODE_STOP))) ||
		((state_q == S_SCAN) && !freeze && expire && held_v_q) ||
		((state_q == S_FLUSH) && held_v_q && out_free);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = cmd_idx;
		ram_wdata = {start_slot, delay_m1[DELAY_BITS-1:WHEEL_BITS]};
		if (state_q == S_EXEC) begin
			ram_we = (cmd_q.mode == MODE_START) && id_ok && out_free;
		end else if (state_q == S_SCAN) begin
			ram_we    = hit && !expire;
			ram_waddr = idx_s1;
			ram_wdata = {rd_slot, rd_rounds - 1'b1};
		end
	end

	htw_ram #(
		.WIDTH(ENTRY_BITS),
		.DEPTH(NUM_TIMERS)
	) u_entry_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(rd_idx_q[IDX_BITS-1:0]),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cmd_q       <= '0;
			tick_q      <= '0;
			pending_q   <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
			held_v_q    <= 1'b0;
			held_id_q   <= '0;
			rd_idx_q    <= '0;
			v_s1        <= 1'b0;
			idx_s1      <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (evt_valid && !evt_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						cmd_q   <= cmd;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					case (cmd_q.mode) inside
						MODE_TICK: begin
							tick_q   <= tick_q + 1'b1;
							rd_idx_q <= '0;
							v_s1     <= 1'b0;
							state_q  <= S_SCAN;
						end
						MODE_START, MODE_STOP: begin
							if (out_free) begin
								out_q.kind         <= cmd_q.mode;
								out_q.timer_id_res <= cmd_q.timer_id;
								out_q.was_pending  <= id_ok && pending_q[cmd_idx];
								out_q.last         <= 1'b1;
								if (id_ok) begin
									pending_q[cmd_idx] <= (cmd_q.mode == MODE_START);
								end
								state_q <= S_IDLE;
							end
						end
						default: begin
							state_q <= S_IDLE;
						end
					endcase
				end
				S_SCAN: begin
					if (!freeze) begin
						v_s1   <= rd_more;
						idx_s1 <= rd_idx_q[IDX_BITS-1:0];
						if (rd_more) begin
							rd_idx_q <= rd_idx_q + 1'b1;
						end
						if (expire) begin
							pending_q[idx_s1] <= 1'b0;
							held_v_q          <= 1'b1;
							held_id_q         <= idx_s1;
							if (held_v_q) begin
								out_q.kind         <= KIND_EXPIRE;
								out_q.timer_id_res <= ID_BITS'(held_id_q);
								out_q.was_pending  <= 1'b0;
								out_q.last         <= 1'b0;
							end
						end
						if (!rd_more && !v_s1) begin
							state_q <= S_FLUSH;
						end
					end
				end
				S_FLUSH: begin
					// The final expiry of the tick is only known once the scan is over.
					if (!held_v_q) begin
						state_q <= S_IDLE;
					end else if (out_free) begin
						out_q.kind         <= KIND_EXPIRE;
						out_q.timer_id_res <= ID_BITS'(held_id_q);
						out_q.was_pending  <= 1'b0;
						out_q.last         <= 1'b1;
						held_v_q           <= 1'b0;
						state_q            <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign cmd_stall = (state_q != S_IDLE);
	assign evt_valid = out_valid_q;
	assign evt       = out_q;

	`HTW_ASSERT(a_no_held_when_idle, clk, arst_n, !((state_q == S_IDLE) && held_v_q), "held expiry left behind at end of tick")
	`HTW_ASSERT(a_expire_clears_pending, clk, arst_n, (state_q == S_SCAN && expire && !freeze) |=> !pending_q[$past(idx_s1)], "expired timer still armed")
	`HTW_ASSERT(a_no_rw_same_entry, clk, arst_n, (ram_we && ram_re) |-> (ram_waddr != rd_idx_q[IDX_BITS-1:0]), "entry RAM read and written at one address")
	`HTW_ASSERT(a_evt_hold, clk, arst_n, (evt_valid && evt_stall) |=> (evt_valid && $stable(evt)), "result changed while stalled")
endmodule
`default_nettype wire
